[rtl/core/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, constants and the divider step of the rgb to hsv converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned HUE_W     = 13;
    localparam int unsigned QUO_W     = 10;               // quotient bits, hue up to 960
    localparam int unsigned NUM_W     = QUO_W + CHAN_W;   // dividend bits
    localparam int unsigned DIV_STEPS = QUO_W;

    localparam logic [HUE_W-1:0] HUE_RED   = 13'd0;
    localparam logic [HUE_W-1:0] HUE_GREEN = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL  = 13'd5760;

    // divider word: remainder in the upper bits, dividend / quotient bits below
    typedef logic [NUM_W-1:0] t_div_word;

    typedef struct packed {
        t_div_word               hue_w;
        logic [CHAN_W-1:0]       hue_den;
        t_div_word               sat_w;
        logic [CHAN_W-1:0]       sat_den;
        logic                    neg;
        logic [HUE_W-1:0]        base;
        logic                    gray;
        logic                    black;
        logic [CHAN_W-1:0]       value;
    } t_pipe;

    // one restoring division step, remainder stays below the divisor
    function automatic t_div_word div_step(input t_div_word w, input logic [CHAN_W-1:0] den);
        logic [CHAN_W:0]   trial;
        logic [CHAN_W:0]   diff;
        logic              take;
        logic [CHAN_W-1:0] rem;
        trial = w[NUM_W-1 -: (CHAN_W + 1)];
        diff  = trial - {1'b0, den};
        take  = (trial >= {1'b0, den});
        rem   = take ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
        return {rem, w[QUO_W-2:0], take};
    endfunction

endpackage

[rtl/core/rgb_to_hsv_convert_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top
// Pipelined rgb to hsv pixel converter with restoring dividers for hue and
// saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  pixel    in         i_valid / o_stall    i_red, i_green, i_blue
//  hsv      out        o_valid / i_stall    o_hue_x16, o_saturation, o_value
//
//  one pixel per clock sustained when nothing stalls; 13 register stages, which a
//  pixel passes in order before o_valid rises: the front compare stage, the
//  scaling stage, the 10 quotient-bit stages of the two parallel dividers and
//  the output register
//  reset clears all valid bits, payload registers are not reset
//  a stalled stage holds, empty stages ahead of it still fill (bubbles squeeze out)
//  o_stall rises only when every stage holds a word and the output is stalled
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [12:0] o_hue_x16,
    output logic [7:0]  o_saturation,
    output logic [7:0]  o_value
);

    localparam int unsigned N = rgbhsv_pkg::DIV_STEPS;

    // front stage
    logic                                r_fv;
    logic [rgbhsv_pkg::CHAN_W-1:0]       r_f_abs;
    logic [rgbhsv_pkg::CHAN_W-1:0]       r_f_d;
    logic [rgbhsv_pkg::CHAN_W-1:0]       r_f_max;
    logic                                r_f_neg;
    logic [rgbhsv_pkg::HUE_W-1:0]        r_f_base;

    rgbhsv_pkg::t_pipe                   r_p  [0:N];
    logic                                r_pv [0:N];

    logic                                r_ov;
    logic [rgbhsv_pkg::HUE_W-1:0]        r_hue;
    logic [rgbhsv_pkg::CHAN_W-1:0]       r_sat;
    logic [rgbhsv_pkg::CHAN_W-1:0]       r_val;

    logic                                rdy_out;
    logic                                rdy_f;
    logic                                rdy_p [0:N];

    // ready chain, a stage moves when it is empty or the next one moves
    always_comb begin
        rdy_out = !r_ov || !i_stall;
        rdy_p[N] = !r_pv[N] || rdy_out;
        for (int k = N - 1; k >= 0; k--) begin
            rdy_p[k] = !r_pv[k] || rdy_p[k+1];
        end
        rdy_f = !r_fv || rdy_p[0];
    end

    assign o_stall = !rdy_f;

    // front: max, min, sector select and signed difference
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [12:0] base;
    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (i_blue > mx) ? i_blue : mx;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (i_blue < mn) ? i_blue : mn;
        if (i_blue == mx) begin
            sa = i_red;   sb = i_green; base = rgbhsv_pkg::HUE_BLUE;
        end else if (i_green == mx) begin
            sa = i_blue;  sb = i_red;   base = rgbhsv_pkg::HUE_GREEN;
        end else begin
            sa = i_green; sb = i_blue;  base = rgbhsv_pkg::HUE_RED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (rdy_f) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_f) begin
            r_f_neg  <= (sa < sb);
            r_f_abs  <= (sa < sb) ? (sb - sa) : (sa - sb);
            r_f_d    <= mx - mn;
            r_f_max  <= mx;
            r_f_base <= base;
        end
    end

    // scaling: 960 * |a - b| and 255 * (max - min)
    rgbhsv_pkg::t_pipe n_p0;
    always_comb begin
        n_p0.hue_w   = ({r_f_abs, 10'd0} - {4'd0, r_f_abs, 6'd0});
        n_p0.hue_den = r_f_d;
        n_p0.sat_w   = {2'd0, ({r_f_d, 8'd0} - {8'd0, r_f_d})};
        n_p0.sat_den = r_f_max;
        n_p0.neg     = r_f_neg;
        n_p0.base    = r_f_base;
        n_p0.gray    = (r_f_d == 8'd0);
        n_p0.black   = (r_f_max == 8'd0);
        n_p0.value   = r_f_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else if (rdy_p[0]) begin
            r_pv[0] <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_p[0]) begin
            r_p[0] <= n_p0;
        end
    end

    // divider stages, one quotient bit each for both divisions
    for (genvar j = 1; j <= N; j++) begin : g_div
        rgbhsv_pkg::t_pipe n_p;
        always_comb begin
            n_p       = r_p[j-1];
            n_p.hue_w = rgbhsv_pkg::div_step(r_p[j-1].hue_w, r_p[j-1].hue_den);
            n_p.sat_w = rgbhsv_pkg::div_step(r_p[j-1].sat_w, r_p[j-1].sat_den);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[j] <= 1'b0;
            end else if (rdy_p[j]) begin
                r_pv[j] <= r_pv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy_p[j]) begin
                r_p[j] <= n_p;
            end
        end
    end

    // final: floor for negative differences, sector offset and wrap, zero hue for gray, zero saturation for black
    logic [9:0]  q_h;
    logic [7:0]  rem_h;
    logic [10:0] mag;
    logic [12:0] top;
    logic [12:0] n_hue;
    logic [7:0]  n_sat;
    always_comb begin
        q_h   = r_p[N].hue_w[rgbhsv_pkg::QUO_W-1:0];
        rem_h = r_p[N].hue_w[rgbhsv_pkg::NUM_W-1 -: rgbhsv_pkg::CHAN_W];
        mag   = {1'b0, q_h} + {10'd0, (r_p[N].neg && (rem_h != 8'd0))};
        top   = (r_p[N].base == rgbhsv_pkg::HUE_RED) ? rgbhsv_pkg::HUE_FULL : r_p[N].base;
        if (r_p[N].gray) begin
            n_hue = 13'd0;
        end else if (r_p[N].neg) begin
            n_hue = top - {2'd0, mag};
        end else begin
            n_hue = r_p[N].base + {3'd0, q_h};
        end
        n_sat = r_p[N].black ? 8'd0 : r_p[N].sat_w[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_out) begin
            r_ov <= r_pv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= r_p[N].value;
        end
    end

    assign o_valid      = r_ov;
    assign o_hue_x16    = r_hue;
    assign o_saturation = r_sat;
    assign o_value      = r_val;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_x16 < rgbhsv_pkg::HUE_FULL))
        else $error("hue out of range");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_value == 8'd0)) |-> (o_saturation == 8'd0))
        else $error("black pixel with nonzero saturation");

    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_saturation == 8'd0) && (o_value != 8'd0)) |-> (o_hue_x16 == 13'd0))
        else $error("gray pixel with nonzero hue");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_ov && i_stall && r_fv && r_pv[0] && r_pv[N]))
        else $error("input stalled while pipeline has room");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv[N] && rdy_out) |=> o_valid)
        else $error("word lost at output register");

endmodule
